[rtl/pfdm_pkg.sv]
// Package for the pulse frequency and duty meter.
// Holds widths, register indexes, reset values, enum types and the
// command and status structs shared by the controller and the datapath.
package pfdm_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int FREQ_W      = 28;
  localparam int TMO_W       = 32;
  localparam int DUTY_W      = 7;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 32;

  localparam int PROD_W    = COUNT_WIDTH + DUTY_W;
  localparam int DVD_W     = (PROD_W > FREQ_W) ? PROD_W : FREQ_W;
  localparam int DIV_CNT_W = $clog2(DVD_W);

  localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_RATE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT = 1'd1;

  localparam logic [FREQ_W-1:0] CLOCK_RATE_RST   = 28'd120000000;
  localparam logic [TMO_W-1:0]  IDLE_TIMEOUT_RST = 32'd65535;
  localparam logic [DUTY_W-1:0] PCT_SCALE        = 7'd100;
  localparam logic [DUTY_W-1:0] DUTY_MAX         = 7'd100;

  localparam logic REPORT_MEAS  = 1'b0;
  localparam logic REPORT_NOSIG = 1'b1;

  typedef enum logic [1:0] {
    PH_WAIT_RISE  = 2'd0,
    PH_WAIT_FALL  = 2'd1,
    PH_WAIT_RISE2 = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE      = 3'd0,
    ST_FREQ_GO   = 3'd1,
    ST_FREQ_WAIT = 3'd2,
    ST_DUTY_GO   = 3'd3,
    ST_DUTY_WAIT = 3'd4,
    ST_EMIT      = 3'd5
  } ctrl_state_t;

  typedef struct packed {
    logic step_en;
    logic div_start;
    logic div_sel_duty;
    logic freq_load;
    logic duty_load;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic step_meas;
    logic step_nosig;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

[rtl/pwm_frequency_duty_meter.sv]
// Top level of the pulse frequency and duty meter.
// Joins the controller pfdm_ctrl and the datapath pfdm_dp; uses pfdm_pkg.
//
//   Channel  Direction  Handshake          Payload
//   in_      input      in_valid/in_stall   in_signal_level
//   out_     output     out_valid/out_stall out_report_kind, out_frequency_hz,
//                                           out_duty_percent, out_level_now
//   cfg_     input      cfg_we              cfg_index, cfg_data
//
// A sample that completes no report leaves the controller idle, so samples stream
// at one per clock while no report is in progress. A no-signal report stalls the
// input in the emit state until the output register is free. A completed
// measurement runs two divisions on the shared divider, one quotient bit per cycle.
// Reset is synchronous and active low and restores the register defaults.
// A stalled output keeps its transaction; one more report may be staged behind it.
module pwm_frequency_duty_meter (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [pfdm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pfdm_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_signal_level,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_report_kind,
  output logic [pfdm_pkg::FREQ_W-1:0]        out_frequency_hz,
  output logic [pfdm_pkg::DUTY_W-1:0]        out_duty_percent,
  output logic                               out_level_now
);
  import pfdm_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  pfdm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  pfdm_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_signal_level  (in_signal_level),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_report_kind  (out_report_kind),
    .out_frequency_hz (out_frequency_hz),
    .out_duty_percent (out_duty_percent),
    .out_level_now    (out_level_now),
    .cmd              (cmd),
    .status           (status)
  );

endmodule

[rtl/pfdm_div.sv]
// Iterative restoring divider for the meter, one quotient bit per cycle.
// Depends on pfdm_pkg for the dividend and count widths.
module pfdm_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [pfdm_pkg::DVD_W-1:0]         dividend,
  input  logic [pfdm_pkg::COUNT_WIDTH-1:0]   divisor,
  output logic                               done,
  output logic [pfdm_pkg::DVD_W-1:0]         quotient
);
  import pfdm_pkg::*;

  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [DIV_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [DVD_W-1:0]       dvd_r, dvd_nxt;
  logic [COUNT_WIDTH-1:0] rem_r, rem_nxt;
  logic [COUNT_WIDTH-1:0] dsr_r, dsr_nxt;
  logic [COUNT_WIDTH:0]   rem_sh;
  logic [COUNT_WIDTH:0]   rem_diff;
  logic                   q_bit;

  always_comb begin
    rem_sh   = {rem_r, dvd_r[DVD_W-1]};
    rem_diff = rem_sh - {1'b0, dsr_r};
    q_bit    = (rem_sh >= {1'b0, dsr_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DVD_W - 1);
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[DVD_W-2:0], q_bit};
      rem_nxt = q_bit ? rem_diff[COUNT_WIDTH-1:0] : rem_sh[COUNT_WIDTH-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = dvd_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r) && !busy_r)
    else $error("divider done without a running division");

endmodule

[rtl/pfdm_ctrl.sv]
// Controller state machine for the meter: sequences step acceptance,
// the two divisions and the hand-off to the output register. Uses pfdm_pkg.
module pfdm_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  pfdm_pkg::dp_status_t   status,
  output pfdm_pkg::ctrl_cmd_t    cmd
);
  import pfdm_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (status.step_meas) begin
            state_nxt = ST_FREQ_GO;
          end else if (status.step_nosig) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_FREQ_GO:   state_nxt = ST_FREQ_WAIT;
      ST_FREQ_WAIT: if (status.div_done) state_nxt = ST_DUTY_GO;
      ST_DUTY_GO:   state_nxt = ST_DUTY_WAIT;
      ST_DUTY_WAIT: if (status.div_done) state_nxt = ST_EMIT;
      ST_EMIT:      if (status.out_free) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.step_en = in_valid;
      end
      ST_FREQ_GO: begin
        cmd.div_start = 1'b1;
      end
      ST_FREQ_WAIT: begin
        cmd.freq_load = status.div_done;
      end
      ST_DUTY_GO: begin
        cmd.div_start    = 1'b1;
        cmd.div_sel_duty = 1'b1;
      end
      ST_DUTY_WAIT: begin
        cmd.duty_load = status.div_done;
      end
      ST_EMIT: begin
        cmd.out_load = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_freq_then_duty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FREQ_WAIT && status.div_done) |=> state_r == ST_DUTY_GO)
    else $error("duty division did not follow frequency division");

  a_meas_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step_en && status.step_meas) |=> cmd.div_start && !cmd.div_sel_duty)
    else $error("completed measurement did not start the frequency division");

endmodule

[rtl/pfdm_dp.sv]
// Datapath of the meter: edge capture, tick and idle counters, configuration
// registers, the shared divider, result staging and the output register.
// Depends on pfdm_pkg and pfdm_div.
module pfdm_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [pfdm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pfdm_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_signal_level,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic                                out_report_kind,
  output logic [pfdm_pkg::FREQ_W-1:0]         out_frequency_hz,
  output logic [pfdm_pkg::DUTY_W-1:0]         out_duty_percent,
  output logic                                out_level_now,
  input  pfdm_pkg::ctrl_cmd_t                 cmd,
  output pfdm_pkg::dp_status_t                status
);
  import pfdm_pkg::*;

  logic [FREQ_W-1:0]      clock_rate_r;
  logic [TMO_W-1:0]       timeout_r;
  phase_t                 phase_r, phase_nxt;
  logic [COUNT_WIDTH-1:0] tick_r;
  logic [COUNT_WIDTH-1:0] first_rise_r, first_rise_nxt;
  logic [COUNT_WIDTH-1:0] fall_r, fall_nxt;
  logic                   prev_level_r;
  logic [TMO_W-1:0]       idle_r, idle_nxt;
  logic [COUNT_WIDTH-1:0] period_r, high_r;
  logic                   res_kind_r;
  logic [FREQ_W-1:0]      res_freq_r;
  logic [DUTY_W-1:0]      res_duty_r;
  logic                   res_level_r;
  logic                   out_valid_r;
  logic                   out_kind_r;
  logic [FREQ_W-1:0]      out_freq_r;
  logic [DUTY_W-1:0]      out_duty_r;
  logic                   out_level_r;

  logic                   rise, fall, done_meas, meas_ok, nosig;
  logic [COUNT_WIDTH-1:0] period, high;
  logic [TMO_W-1:0]       idle_inc;
  logic [PROD_W-1:0]      prod;
  logic [DVD_W-1:0]       div_dividend;
  logic [DVD_W-1:0]       div_quotient;
  logic                   div_done;
  logic [DUTY_W-1:0]      duty_sat;

  always_comb begin
    rise           = in_signal_level && !prev_level_r;
    fall           = !in_signal_level && prev_level_r;
    period         = tick_r - first_rise_r;
    high           = fall_r - first_rise_r;
    meas_ok        = (period != '0) && (high != '0);
    done_meas      = 1'b0;
    phase_nxt      = phase_r;
    first_rise_nxt = first_rise_r;
    fall_nxt       = fall_r;
    case (phase_r)
      PH_WAIT_FALL: begin
        if (fall) begin
          fall_nxt  = tick_r;
          phase_nxt = PH_WAIT_RISE2;
        end
      end
      PH_WAIT_RISE2: begin
        if (rise) begin
          done_meas = 1'b1;
          phase_nxt = PH_WAIT_RISE;
        end
      end
      default: begin
        if (rise) begin
          first_rise_nxt = tick_r;
          phase_nxt      = PH_WAIT_FALL;
        end else begin
          phase_nxt = PH_WAIT_RISE;
        end
      end
    endcase
    idle_inc = idle_r + 1'b1;
    nosig    = !done_meas && (idle_inc >= timeout_r);
    idle_nxt = (done_meas || nosig) ? '0 : idle_inc;
  end

  assign prod         = PROD_W'(high_r) * PROD_W'(PCT_SCALE);
  assign div_dividend = cmd.div_sel_duty ? DVD_W'(prod) : DVD_W'(clock_rate_r);
  assign duty_sat     = (div_quotient > DVD_W'(DUTY_MAX)) ? DUTY_MAX
                                                          : div_quotient[DUTY_W-1:0];

  pfdm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (period_r),
    .done     (div_done),
    .quotient (div_quotient)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_rate_r <= CLOCK_RATE_RST;
      timeout_r    <= IDLE_TIMEOUT_RST;
      phase_r      <= PH_WAIT_RISE;
      tick_r       <= '0;
      first_rise_r <= '0;
      fall_r       <= '0;
      prev_level_r <= 1'b0;
      idle_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CLOCK_RATE:   clock_rate_r <= cfg_data[FREQ_W-1:0];
          CFG_IDLE_TIMEOUT: timeout_r    <= cfg_data[TMO_W-1:0];
          default:          timeout_r    <= timeout_r;
        endcase
      end
      if (cmd.step_en) begin
        phase_r      <= phase_nxt;
        tick_r       <= tick_r + 1'b1;
        first_rise_r <= first_rise_nxt;
        fall_r       <= fall_nxt;
        prev_level_r <= in_signal_level;
        idle_r       <= idle_nxt;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step_en && done_meas && meas_ok) begin
      period_r    <= period;
      high_r      <= high;
      res_kind_r  <= REPORT_MEAS;
      res_level_r <= in_signal_level;
    end else if (cmd.step_en && nosig) begin
      res_kind_r  <= REPORT_NOSIG;
      res_freq_r  <= '0;
      res_duty_r  <= '0;
      res_level_r <= in_signal_level;
    end
    if (cmd.freq_load) begin
      res_freq_r <= div_quotient[FREQ_W-1:0];
    end
    if (cmd.duty_load) begin
      res_duty_r <= duty_sat;
    end
    if (cmd.out_load) begin
      out_kind_r  <= res_kind_r;
      out_freq_r  <= res_freq_r;
      out_duty_r  <= res_duty_r;
      out_level_r <= res_level_r;
    end
  end

  always_comb begin
    status.step_meas  = done_meas && meas_ok;
    status.step_nosig = nosig;
    status.div_done   = div_done;
    status.out_free   = !out_valid_r || !out_stall;
  end

  assign out_valid        = out_valid_r;
  assign out_report_kind  = out_kind_r;
  assign out_frequency_hz = out_freq_r;
  assign out_duty_percent = out_duty_r;
  assign out_level_now    = out_level_r;

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || !out_stall))
    else $error("output register overwritten while a transaction is pending");

  a_duty_only_meas: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.duty_load |-> res_kind_r == REPORT_MEAS)
    else $error("duty written into a no-signal report");

endmodule
